// ===== sv/twv_pkg.sv =====
// Package with the shared constants and widths of the trapped water volume block.
package twv_pkg;

	// Storage depth and column height width.
	localparam int MAX_LEN     = 32768;
	localparam int HEIGHT_BITS = 16;

	// Derived widths: memory address, column count (holds MAX_LEN itself), total.
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int WATER_W = 31;

	// One memory entry holds the prefix maximum above the column height.
	localparam int ENTRY_W = 2 * HEIGHT_BITS;

	localparam logic [WATER_W-1:0] WATER_LIMIT = {WATER_W{1'b1}};
	localparam logic [CNT_W-1:0]   MAX_COUNT   = CNT_W'(MAX_LEN);

	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [WATER_W-1:0]     water_t;
	typedef logic [CNT_W-1:0]       count_t;
	typedef logic [ADDR_W-1:0]      addr_t;

endpackage

// ===== sv/twv_col_if.sv =====
// Interface for the column request channel.
interface twv_col_if;
	import twv_pkg::*;

	logic    valid;
	logic    ready;
	height_t column_height;
	logic    last_column;

	modport source (output valid, output column_height, output last_column, input ready);
	modport sink   (input valid, input column_height, input last_column, output ready);
endinterface

// ===== sv/twv_res_if.sv =====
// Interface for the result request channel.
interface twv_res_if;
	import twv_pkg::*;

	logic   valid;
	logic   ready;
	water_t water_total;
	logic   overflowed;

	modport source (output valid, output water_total, output overflowed, input ready);
	modport sink   (input valid, input water_total, input overflowed, output ready);
endinterface

// ===== sv/twv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module twv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== sv/trapped_water_volume_top.sv =====
// Top level of the trapped water volume block: column store, backward walk, result register.
//
//   Channel   Dir   Payload                          Handshake
//   columns   in    column_height[16], last_column   valid/ready
//   result    out   water_total[31], overflowed      valid/ready
//
// Each column request is taken while loading and, while the memory has room, written
// to the column memory together with its prefix maximum. After the last column, the walk
// reads the N stored entries from right to left, one per cycle, through the single memory
// read port, and the result is loaded into the result register once the walk is finished.
// Reset clears all control state; the memory is not cleared, only written entries are read.
// No column is taken during the walk; a pending result stalls only the end of the next walk.
module trapped_water_volume_top (
	input  logic       clk,
	input  logic       arst_n,
	twv_col_if.sink    columns,
	twv_res_if.source  result
);
	import twv_pkg::*;

	typedef enum logic {ST_LOAD, ST_WALK} state_t;

	state_t  state_q;
	count_t  count_q;
	height_t run_max_q;
	logic    ovf_q;
	count_t  rd_cnt_q;
	height_t suffix_q;
	logic    vld_s1;
	logic    vld_s2;
	height_t diff_s2;
	water_t  acc_q;
	logic    out_valid_q;
	water_t  out_total_q;
	logic    out_ovf_q;

	logic                 col_acc;
	logic                 room;
	logic                 wr_en;
	height_t              max_next;
	count_t               cnt_next;
	logic                 rd_en;
	addr_t                rd_addr;
	logic [ENTRY_W-1:0]   rd_data;
	height_t              rd_height;
	height_t              rd_prefix;
	height_t              suf_next;
	height_t              level;
	logic [WATER_W:0]     acc_sum;
	water_t               acc_next;
	logic                 walk_done;

	// Column intake and memory write.
	assign columns.ready = (state_q == ST_LOAD);
	assign col_acc       = columns.valid && columns.ready;
	assign room          = (count_q < MAX_COUNT);
	assign wr_en         = col_acc && room;
	assign max_next      = (columns.column_height > run_max_q) ? columns.column_height
	                                                           : run_max_q;
	assign cnt_next      = wr_en ? count_q + count_t'(1) : count_q;

	// Backward walk: issue reads from the last stored column down to the first.
	assign rd_en   = (state_q == ST_WALK) && (rd_cnt_q != '0);
	assign rd_addr = ADDR_W'(rd_cnt_q - count_t'(1));

	twv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_LEN)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data ({max_next, columns.column_height}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Water level of the column just read; the level never drops below the height.
	assign rd_height = rd_data[HEIGHT_BITS-1:0];
	assign rd_prefix = rd_data[ENTRY_W-1:HEIGHT_BITS];
	assign suf_next  = (rd_height > suffix_q) ? rd_height : suffix_q;
	assign level     = (rd_prefix < suf_next) ? rd_prefix : suf_next;

	// Saturating accumulation of the per-column water.
	assign acc_sum  = {1'b0, acc_q} + {{(WATER_W + 1 - HEIGHT_BITS){1'b0}}, diff_s2};
	assign acc_next = (acc_sum > {1'b0, WATER_LIMIT}) ? WATER_LIMIT : acc_sum[WATER_W-1:0];

	// The walk is finished once all reads are issued, the pipeline is empty and the result register is free.
	assign walk_done = (state_q == ST_WALK) && (rd_cnt_q == '0) && !vld_s1 && !vld_s2
	                   && (!out_valid_q || result.ready);

	// State, walk pipeline and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			run_max_q   <= '0;
			ovf_q       <= 1'b0;
			rd_cnt_q    <= '0;
			suffix_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			diff_s2     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_total_q <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			if (walk_done) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (col_acc) begin
						if (room) begin
							run_max_q <= max_next;
						end else begin
							ovf_q <= 1'b1;
						end
						count_q <= cnt_next;
						if (columns.last_column) begin
							rd_cnt_q <= cnt_next;
							suffix_q <= '0;
							acc_q    <= '0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q - count_t'(1);
					end
					if (vld_s1) begin
						suffix_q <= suf_next;
						diff_s2  <= level - rd_height;
					end
					if (vld_s2) begin
						acc_q <= acc_next;
					end
					if (walk_done) begin
						out_total_q <= acc_q;
						out_ovf_q   <= ovf_q;
						count_q     <= '0;
						run_max_q   <= '0;
						ovf_q       <= 1'b0;
						acc_q       <= '0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.water_total = out_total_q;
	assign result.overflowed  = out_ovf_q;

	// The column count never passes the memory depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_COUNT)
		else $error("column count beyond memory depth");

	// The memory is never written while the walk reads it.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !wr_en)
		else $error("memory write during walk");

	// Overflow is only flagged once the memory is full.
	a_ovf_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!ovf_q && col_acc && !room) |-> (count_q == MAX_COUNT))
		else $error("overflow flagged with room left");

	// A new result is only loaded when the previous one is gone or taken.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> (!out_valid_q || result.ready))
		else $error("pending result overwritten");

	// Read data is only consumed the cycle after a read was issued.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(rd_en) && (state_q == ST_WALK)))
		else $error("read data used without a read");
endmodule
